/* hdl/phong_pixel_shader_assert.svh */
// Assertion macros shared by the Phong pixel shader datapath modules.
// Depends on nothing; included by the modules that carry assertions.
`ifndef PHONG_PIXEL_SHADER_ASSERT_SVH
`define PHONG_PIXEL_SHADER_ASSERT_SVH

// The condition must hold in the same cycle as the trigger.
`define PHPS_ASSERT_IMPLY(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("phong_pixel_shader: same-cycle check failed");

// The condition must hold in the cycle after the trigger.
`define PHPS_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("phong_pixel_shader: next-cycle check failed");

`endif

/* hdl/phps_pkg.sv */
// Shared types, register map and width helpers of the Phong pixel shader.
// Depends on nothing; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package phps_pkg;

    // One ray hit: view direction, surface normal and base color.
    typedef struct packed {
        logic signed [15:0] view_x;
        logic signed [15:0] view_y;
        logic signed [15:0] view_z;
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
        logic [7:0]         base_red;
        logic [7:0]         base_green;
        logic [7:0]         base_blue;
    } hit_t;

    // One shaded pixel.
    typedef struct packed {
        logic [7:0] shade_red;
        logic [7:0] shade_green;
        logic [7:0] shade_blue;
    } shade_t;

    // Configuration registers as seen by the datapath.
    typedef struct packed {
        logic [7:0] ambient_level;
        logic [8:0] diffuse_gain;
        logic [8:0] specular_gain;
    } cfg_t;

    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    // Register indexes (byte address bits 3:2).
    localparam logic [1:0] REG_AMBIENT  = 2'd0;
    localparam logic [1:0] REG_DIFFUSE  = 2'd1;
    localparam logic [1:0] REG_SPECULAR = 2'd2;

    localparam logic [7:0] AMBIENT_RST  = 8'd26;
    localparam logic [8:0] DIFFUSE_RST  = 9'd128;
    localparam logic [8:0] SPECULAR_RST = 9'd128;

    // Width of the floored dot product d for a given number of fraction bits.
    function automatic int d_width(int frac);
        return 33 - frac;
    endfunction

    // Width of the signed brightness ambient * 2^F - d * diffuse_gain.
    function automatic int bright_width(int frac);
        int dw;
        dw = 33 - frac;
        return ((frac + 9 > dw + 10) ? frac + 9 : dw + 10) + 1;
    endfunction

endpackage

`default_nettype wire

/* hdl/phps_regs.sv */
// APB configuration registers of the Phong pixel shader.
// Depends on phps_pkg for the register map and reset values.
`timescale 1ns / 1ps
`default_nettype none

module phps_regs (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [phps_pkg::ADDR_W-1:0] paddr,
    input  wire logic [phps_pkg::DATA_W-1:0] pwdata,
    output logic      [phps_pkg::DATA_W-1:0] prdata,
    output logic                             pready,
    output phps_pkg::cfg_t                   cfg
);

    logic [7:0] ambient_level_reg;
    logic [8:0] diffuse_gain_reg;
    logic [8:0] specular_gain_reg;
    logic       wr_en;

    // A write transfer completes in the access phase; pready is always high.
    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;

    // Register file; writes to unmapped addresses are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ambient_level_reg <= phps_pkg::AMBIENT_RST;
            diffuse_gain_reg  <= phps_pkg::DIFFUSE_RST;
            specular_gain_reg <= phps_pkg::SPECULAR_RST;
        end
        else if (wr_en)
        begin
            case (paddr[3:2])
                phps_pkg::REG_AMBIENT:  ambient_level_reg <= pwdata[7:0];
                phps_pkg::REG_DIFFUSE:  diffuse_gain_reg  <= pwdata[8:0];
                phps_pkg::REG_SPECULAR: specular_gain_reg <= pwdata[8:0];
                default:                ;
            endcase
        end
    end

    // Read data mux.
    always_comb
    begin
        case (paddr[3:2])
            phps_pkg::REG_AMBIENT:  prdata = {24'd0, ambient_level_reg};
            phps_pkg::REG_DIFFUSE:  prdata = {23'd0, diffuse_gain_reg};
            phps_pkg::REG_SPECULAR: prdata = {23'd0, specular_gain_reg};
            default:                prdata = '0;
        endcase
    end

    assign cfg.ambient_level = ambient_level_reg;
    assign cfg.diffuse_gain  = diffuse_gain_reg;
    assign cfg.specular_gain = specular_gain_reg;

endmodule

`default_nettype wire

/* hdl/phps_vector.sv */
// Vector front end of the shader: dot product, reflection, specular cosine
// and brightness, six register stages. Depends on phps_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "phong_pixel_shader_assert.svh"

module phps_vector #(
    parameter int VEC_FRAC_BITS = 14
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    input  wire phps_pkg::hit_t        hit,
    input  wire phps_pkg::cfg_t        cfg,
    output logic                       out_valid,
    output logic [VEC_FRAC_BITS:0]     cosine,
    output logic signed [phps_pkg::bright_width(VEC_FRAC_BITS)-1:0] bright,
    output logic [2:0][7:0]            base
);

    localparam int F    = VEC_FRAC_BITS;
    localparam int DOTW = 33;
    localparam int DW   = phps_pkg::d_width(F);
    localparam int BW   = phps_pkg::bright_width(F);
    localparam int PW   = DW + 17;
    localparam int RW   = PW + 1;
    localparam int RVW  = RW + 16;
    localparam int SUMW = RVW + 2;
    localparam logic signed [SUMW-1:0] S_ONE = SUMW'(1) << F;

    logic [5:0] valid_reg;

    logic signed [15:0] vin [3];
    logic signed [15:0] nin [3];

    // Stage 1: componentwise products.
    logic signed [31:0]  prod1_reg [3];
    logic signed [15:0]  v1_reg    [3];
    logic signed [15:0]  n1_reg    [3];
    logic [2:0][7:0]     base1_reg;
    // Stage 2: floored dot product.
    logic signed [DOTW-1:0] dot_sum;
    logic signed [DW-1:0]   d2_next;
    logic signed [DW-1:0]   d2_reg;
    logic signed [15:0]     v2_reg [3];
    logic signed [15:0]     n2_reg [3];
    logic [2:0][7:0]        base2_reg;
    // Stage 3: reflection term and brightness.
    logic signed [DW+15:0]  dn      [3];
    logic signed [PW-1:0]   dn2     [3];
    logic signed [PW-1:0]   t3_next [3];
    logic signed [PW-1:0]   t3_reg  [3];
    logic signed [BW-1:0]   amb_term;
    logic signed [DW+9:0]   dif_term;
    logic signed [BW-1:0]   bright3_next;
    logic signed [BW-1:0]   bright3_reg;
    logic signed [15:0]     v3_reg [3];
    logic [2:0][7:0]        base3_reg;
    // Stage 4: reflected vector.
    logic signed [RW-1:0]   r4_next [3];
    logic signed [RW-1:0]   r4_reg  [3];
    logic signed [15:0]     v4_reg  [3];
    logic signed [BW-1:0]   bright4_reg;
    logic [2:0][7:0]        base4_reg;
    // Stage 5: reflected dot view products.
    logic signed [RVW-1:0]  rv5_next [3];
    logic signed [RVW-1:0]  rv5_reg  [3];
    logic signed [BW-1:0]   bright5_reg;
    logic [2:0][7:0]        base5_reg;
    // Stage 6: clamped specular cosine.
    logic signed [SUMW-1:0] sum_rv;
    logic signed [SUMW-1:0] sum_s;
    logic [F:0]             s6_next;
    logic [F:0]             s6_reg;
    logic signed [BW-1:0]   bright6_reg;
    logic [2:0][7:0]        base6_reg;

    assign vin[0] = hit.view_x;
    assign vin[1] = hit.view_y;
    assign vin[2] = hit.view_z;
    assign nin[0] = hit.normal_x;
    assign nin[1] = hit.normal_y;
    assign nin[2] = hit.normal_z;

    // Valid bits travel alongside the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[4:0], in_valid};
        end
    end

    // Stage 2 combinational: sum and floor shift.
    always_comb
    begin
        dot_sum = DOTW'(prod1_reg[0]) + DOTW'(prod1_reg[1]) + DOTW'(prod1_reg[2]);
        d2_next = DW'(dot_sum >>> F);
    end

    // Stage 3 combinational: floor(2*d*n / 2^F) and the brightness.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            dn[i]      = d2_reg * n2_reg[i];
            dn2[i]     = {dn[i], 1'b0};
            t3_next[i] = dn2[i] >>> F;
        end
        amb_term     = {{(BW - 8){1'b0}}, cfg.ambient_level} << F;
        dif_term     = d2_reg * $signed({1'b0, cfg.diffuse_gain});
        bright3_next = amb_term - BW'(dif_term);
    end

    // Stages 4 and 5 combinational: reflected vector and its products with v.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            r4_next[i]  = RW'(v3_reg[i]) - RW'(t3_reg[i]);
            rv5_next[i] = r4_reg[i] * v4_reg[i];
        end
    end

    // Stage 6 combinational: floor shift and clamp to 0..1.0.
    always_comb
    begin
        sum_rv = SUMW'(rv5_reg[0]) + SUMW'(rv5_reg[1]) + SUMW'(rv5_reg[2]);
        sum_s  = sum_rv >>> F;
        if (sum_s < 0)
        begin
            s6_next = '0;
        end
        else if (sum_s > S_ONE)
        begin
            s6_next = S_ONE[F:0];
        end
        else
        begin
            s6_next = sum_s[F:0];
        end
    end

    // Datapath registers; no reset on payload.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            prod1_reg[i] <= vin[i] * nin[i];
            v1_reg[i]    <= vin[i];
            n1_reg[i]    <= nin[i];
            v2_reg[i]    <= v1_reg[i];
            n2_reg[i]    <= n1_reg[i];
            t3_reg[i]    <= t3_next[i];
            v3_reg[i]    <= v2_reg[i];
            r4_reg[i]    <= r4_next[i];
            v4_reg[i]    <= v3_reg[i];
            rv5_reg[i]   <= rv5_next[i];
        end
        base1_reg   <= {hit.base_blue, hit.base_green, hit.base_red};
        d2_reg      <= d2_next;
        base2_reg   <= base1_reg;
        bright3_reg <= bright3_next;
        base3_reg   <= base2_reg;
        bright4_reg <= bright3_reg;
        base4_reg   <= base3_reg;
        bright5_reg <= bright4_reg;
        base5_reg   <= base4_reg;
        s6_reg      <= s6_next;
        bright6_reg <= bright5_reg;
        base6_reg   <= base5_reg;
    end

    assign out_valid = valid_reg[5];
    assign cosine    = s6_reg;
    assign bright    = bright6_reg;
    assign base      = base6_reg;

    // The clamp keeps the cosine within 0..1.0.
    `PHPS_ASSERT_IMPLY(a_cosine_range, clk, rst_n, valid_reg[5], s6_reg <= S_ONE[F:0])
    // A negative reflected dot product gives no highlight.
    `PHPS_ASSERT_NEXT(a_cosine_neg, clk, rst_n, valid_reg[4] && (sum_s < 0), s6_reg == '0)
    // Every item leaving the front end came down the valid chain from its first stage.
    `PHPS_ASSERT_IMPLY(a_front_latency, clk, rst_n, valid_reg[5], $past(valid_reg[0], 5))

endmodule

`default_nettype wire

/* hdl/phps_light.sv */
// Lighting back end of the shader: fourth power of the cosine, channel
// mix, rounding and saturation, five register stages. Depends on phps_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "phong_pixel_shader_assert.svh"

module phps_light #(
    parameter int VEC_FRAC_BITS = 14
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic [VEC_FRAC_BITS:0] cosine,
    input  wire logic signed [phps_pkg::bright_width(VEC_FRAC_BITS)-1:0] bright,
    input  wire logic [2:0][7:0]   base,
    input  wire phps_pkg::cfg_t    cfg,
    output logic                   done,
    output phps_pkg::shade_t       shade
);

    localparam int F   = VEC_FRAC_BITS;
    localparam int BW  = phps_pkg::bright_width(F);
    localparam int BBW = BW + 9;
    localparam int NW  = ((BBW > F + 19) ? BBW : F + 19) + 2;
    localparam logic [F:0]             S_ONE    = (F + 1)'(1) << F;
    localparam logic signed [NW-1:0]   RND      = NW'(1) << (F + 7);
    localparam logic signed [NW-1:0]   CHAN_MAX = NW'(255);

    logic [4:0] valid_reg;

    // Stage 1: cosine squared.
    logic [2*F+1:0]       sq1;
    logic [F:0]           s2_next;
    logic [F:0]           s2_reg;
    logic signed [BW-1:0] bright1_reg;
    logic [2:0][7:0]      base1_reg;
    // Stage 2: cosine to the fourth.
    logic [2*F+1:0]       sq2;
    logic [F:0]           spec_next;
    logic [F:0]           spec_reg;
    logic signed [BW-1:0] bright2_reg;
    logic [2:0][7:0]      base2_reg;
    // Stage 3: weighted highlight and base times brightness.
    logic [F+9:0]          sg3_next;
    logic [F+9:0]          sg3_reg;
    logic signed [BBW-1:0] bb3_next [3];
    logic signed [BBW-1:0] bb3_reg  [3];
    // Stage 4: channel numerators with rounding offset.
    logic [F+17:0]         sg255;
    logic signed [NW-1:0]  num4_next [3];
    logic signed [NW-1:0]  num4_reg  [3];
    // Stage 5: saturated channels.
    logic signed [NW-1:0]  q5       [3];
    logic [7:0]            chan5_next [3];
    logic [7:0]            chan5_reg  [3];

    // Valid bits travel alongside the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[3:0], in_valid};
        end
    end

    // Squaring steps; values never exceed 1.0, so F+1 bits suffice.
    always_comb
    begin
        sq1       = cosine * cosine;
        s2_next   = sq1[2*F:F];
        sq2       = s2_reg * s2_reg;
        spec_next = sq2[2*F:F];
    end

    // Stage 3 and 4 combinational: products and the channel sums.
    always_comb
    begin
        sg3_next = spec_reg * cfg.specular_gain;
        sg255    = {sg3_reg, 8'd0} - {8'd0, sg3_reg};
        for (int i = 0; i < 3; i++)
        begin
            bb3_next[i]  = bright2_reg * $signed({1'b0, base2_reg[i]});
            num4_next[i] = NW'(bb3_reg[i]) + NW'($signed({1'b0, sg255})) + RND;
        end
    end

    // Stage 5 combinational: floor shift and saturate to 0..255.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            q5[i] = num4_reg[i] >>> (F + 8);
            if (q5[i] < 0)
            begin
                chan5_next[i] = 8'd0;
            end
            else if (q5[i] > CHAN_MAX)
            begin
                chan5_next[i] = 8'd255;
            end
            else
            begin
                chan5_next[i] = q5[i][7:0];
            end
        end
    end

    // Datapath registers; no reset on payload.
    always_ff @(posedge clk)
    begin
        s2_reg      <= s2_next;
        bright1_reg <= bright;
        base1_reg   <= base;
        spec_reg    <= spec_next;
        bright2_reg <= bright1_reg;
        base2_reg   <= base1_reg;
        sg3_reg     <= sg3_next;
        for (int i = 0; i < 3; i++)
        begin
            bb3_reg[i]   <= bb3_next[i];
            num4_reg[i]  <= num4_next[i];
            chan5_reg[i] <= chan5_next[i];
        end
    end

    assign done              = valid_reg[4];
    assign shade.shade_red   = chan5_reg[0];
    assign shade.shade_green = chan5_reg[1];
    assign shade.shade_blue  = chan5_reg[2];

    // Squares of a cosine in 0..1.0 stay within 0..1.0.
    `PHPS_ASSERT_IMPLY(a_square_range, clk, rst_n, valid_reg[0], s2_reg <= S_ONE)
    `PHPS_ASSERT_IMPLY(a_spec_range, clk, rst_n, valid_reg[1], spec_reg <= S_ONE)
    // Every strobed result came down the valid chain from the back end's first stage.
    `PHPS_ASSERT_IMPLY(a_back_latency, clk, rst_n, valid_reg[4], $past(valid_reg[0], 4))

endmodule

`default_nettype wire

/* hdl/phong_pixel_shader.sv */
// Throughput: one ray hit per clock; busy is always low, start is taken every cycle.
// The 11 register stages (6 vector, 5 lighting) lie between an accepted start and done;
// each result is strobed on done for one cycle and the receiver cannot stall.
// Reset clears all valid bits (no result is strobed) and restores register defaults.
`timescale 1ns / 1ps
`default_nettype none

module phong_pixel_shader #(
    parameter int VEC_FRAC_BITS = 14
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire phps_pkg::hit_t              hit,
    output logic                             done,
    output phps_pkg::shade_t                 shade,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [phps_pkg::ADDR_W-1:0] paddr,
    input  wire logic [phps_pkg::DATA_W-1:0] pwdata,
    output logic      [phps_pkg::DATA_W-1:0] prdata,
    output logic                             pready
);

    localparam int BW = phps_pkg::bright_width(VEC_FRAC_BITS);

    phps_pkg::cfg_t       cfg;
    logic                 mid_valid;
    logic [VEC_FRAC_BITS:0] mid_cosine;
    logic signed [BW-1:0] mid_bright;
    logic [2:0][7:0]      mid_base;

    // The pipeline takes a transfer every cycle.
    assign busy = 1'b0;

    // Configuration registers.
    phps_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Geometry: dot product, reflection, specular cosine, brightness.
    phps_vector #(
        .VEC_FRAC_BITS (VEC_FRAC_BITS)
    ) u_vector (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start & ~busy),
        .hit       (hit),
        .cfg       (cfg),
        .out_valid (mid_valid),
        .cosine    (mid_cosine),
        .bright    (mid_bright),
        .base      (mid_base)
    );

    // Lighting: highlight power, channel mix and saturation.
    phps_light #(
        .VEC_FRAC_BITS (VEC_FRAC_BITS)
    ) u_light (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (mid_valid),
        .cosine   (mid_cosine),
        .bright   (mid_bright),
        .base     (mid_base),
        .cfg      (cfg),
        .done     (done),
        .shade    (shade)
    );

endmodule

`default_nettype wire
